// ----- design/svm4_pkg.sv -----
// Shared types and constants of the four-class int8 linear SVM scorer.
// Used by the front, queue, back and top-level modules; no dependencies.
`default_nettype none

package svm4_pkg;

  localparam int unsigned NUM_CLASSES       = 4;
  localparam int unsigned FEATURE_WORDS_DEF = 256;
  localparam int unsigned QUEUE_DEPTH       = 4;
  localparam int unsigned QPTR_W            = $clog2(QUEUE_DEPTH);
  localparam int unsigned QLVL_W            = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    ACT_LOAD    = 1'b0,
    ACT_FEATURE = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    CFG_BIAS0 = 2'd0,
    CFG_BIAS1 = 2'd1,
    CFG_BIAS2 = 2'd2,
    CFG_BIAS3 = 2'd3
  } cfg_reg_t;

  // One feature word with the weight words of all classes at its position.
  typedef struct packed {
    logic [3:0][7:0]             feat;
    logic [NUM_CLASSES-1:0][31:0] weight;
    logic                        first;
    logic                        active;
    logic                        last;
  } work_t;

endpackage

`default_nettype wire

// ----- design/svm4_front.sv -----
// Front end: accepts items, writes weight words, reads the class rows for
// feature words and tracks the feature position. Depends on svm4_pkg.
`default_nettype none

module svm4_front #(
  parameter int unsigned FeatureWords = svm4_pkg::FEATURE_WORDS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_action,
  input  logic [1:0]                      in_class_sel,
  input  logic [7:0]                      in_word_addr,
  input  logic signed [7:0]               in_byte0,
  input  logic signed [7:0]               in_byte1,
  input  logic signed [7:0]               in_byte2,
  input  logic signed [7:0]               in_byte3,
  input  logic                            in_last,
  input  logic [svm4_pkg::QLVL_W-1:0]     q_level,
  output logic                            push,
  output svm4_pkg::work_t                 push_data
);

  localparam int unsigned AW = (FeatureWords > 1) ? $clog2(FeatureWords) : 1;
  localparam int unsigned CW = $clog2(FeatureWords + 1);
  localparam int unsigned XW = (AW > 8) ? AW : 8;

  logic [svm4_pkg::QLVL_W-1:0] occ;
  logic                        accept;
  logic                        feat_acc;
  logic                        load_acc;
  logic                        addr_ok;
  logic                        active;
  logic [XW-1:0]               addr_x;
  logic [AW-1:0]               wr_idx;
  logic [AW-1:0]               rd_idx;
  logic [31:0]                 word;

  logic [CW-1:0]               count_r;
  logic [CW-1:0]               count_nxt;
  logic                        s1_valid_r;
  logic                        s1_valid_nxt;
  logic [3:0][7:0]             s1_feat_r;
  logic                        s1_first_r;
  logic                        s1_active_r;
  logic                        s1_last_r;

  assign occ      = q_level + svm4_pkg::QLVL_W'(s1_valid_r);
  assign in_stall = (occ >= svm4_pkg::QLVL_W'(svm4_pkg::QUEUE_DEPTH));
  assign accept   = in_valid && !in_stall;
  assign feat_acc = accept && (in_action == svm4_pkg::ACT_FEATURE);
  assign addr_ok  = (32'(in_word_addr) < 32'(FeatureWords));
  assign load_acc = accept && (in_action == svm4_pkg::ACT_LOAD) && addr_ok;
  assign addr_x   = XW'(in_word_addr);
  assign wr_idx   = addr_x[AW-1:0];
  assign active   = (count_r < CW'(FeatureWords));
  assign rd_idx   = count_r[AW-1:0];
  assign word     = {in_byte3, in_byte2, in_byte1, in_byte0};

  always_comb begin
    priority if (!feat_acc) begin
      count_nxt = count_r;
    end else if (in_last) begin
      count_nxt = '0;
    end else if (active) begin
      count_nxt = CW'(count_r + 1'b1);
    end else begin
      count_nxt = count_r;
    end
  end

  assign s1_valid_nxt = feat_acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      count_r    <= count_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (feat_acc) begin
      s1_feat_r   <= word;
      s1_first_r  <= (count_r == '0);
      s1_active_r <= active;
      s1_last_r   <= in_last;
    end
  end

  for (genvar c = 0; c < svm4_pkg::NUM_CLASSES; c++) begin : g_row
    logic [31:0] wmem_r [FeatureWords];
    logic [31:0] wrd_r;

    always_ff @(posedge clk) begin
      if (load_acc && (in_class_sel == 2'(c))) begin
        wmem_r[wr_idx] <= word;
      end
      if (feat_acc && active) begin
        wrd_r <= wmem_r[rd_idx];
      end
    end

    assign push_data.weight[c] = wrd_r;
  end

  assign push             = s1_valid_r;
  assign push_data.feat   = s1_feat_r;
  assign push_data.first  = s1_first_r;
  assign push_data.active = s1_active_r;
  assign push_data.last   = s1_last_r;

endmodule

`default_nettype wire

// ----- design/svm4_queue.sv -----
// Short work queue between the front end and the accumulate back end.
// Depends on svm4_pkg for the entry type and depth.
`default_nettype none

module svm4_queue (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  input  svm4_pkg::work_t             push_data,
  input  logic                        pop,
  output logic                        head_valid,
  output svm4_pkg::work_t             head_data,
  output logic [svm4_pkg::QLVL_W-1:0] level
);

  svm4_pkg::work_t                    entry_r [svm4_pkg::QUEUE_DEPTH];
  logic [svm4_pkg::QPTR_W-1:0]        wr_ptr_r;
  logic [svm4_pkg::QPTR_W-1:0]        wr_ptr_nxt;
  logic [svm4_pkg::QPTR_W-1:0]        rd_ptr_r;
  logic [svm4_pkg::QPTR_W-1:0]        rd_ptr_nxt;
  logic [svm4_pkg::QLVL_W-1:0]        level_r;
  logic [svm4_pkg::QLVL_W-1:0]        level_nxt;
  logic                               do_pop;

  assign head_valid = (level_r != '0);
  assign head_data  = entry_r[rd_ptr_r];
  assign level      = level_r;
  assign do_pop     = pop && head_valid;

  assign wr_ptr_nxt = push   ? svm4_pkg::QPTR_W'(wr_ptr_r + 1'b1) : wr_ptr_r;
  assign rd_ptr_nxt = do_pop ? svm4_pkg::QPTR_W'(rd_ptr_r + 1'b1) : rd_ptr_r;

  always_comb begin
    unique case ({push, do_pop})
      2'b10:   level_nxt = svm4_pkg::QLVL_W'(level_r + 1'b1);
      2'b01:   level_nxt = svm4_pkg::QLVL_W'(level_r - 1'b1);
      default: level_nxt = level_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ----- design/svm4_back.sv -----
// Back end: bias registers, per-class dot products, accumulators and the
// score output register. Depends on svm4_pkg.
`default_nettype none

module svm4_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  logic                head_valid,
  input  svm4_pkg::work_t     head_data,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  out_score0,
  output logic signed [31:0]  out_score1,
  output logic signed [31:0]  out_score2,
  output logic signed [31:0]  out_score3
);

  function automatic logic signed [17:0] dot4(input logic [3:0][7:0] f,
                                              input logic [31:0] w);
    logic signed [17:0] acc;
    acc = '0;
    for (int k = 0; k < 4; k++) begin
      acc = acc + 18'($signed(f[k]) * $signed(w[8*k +: 8]));
    end
    return acc;
  endfunction

  logic [31:0]        bias_r    [svm4_pkg::NUM_CLASSES];
  logic [31:0]        acc_r     [svm4_pkg::NUM_CLASSES];
  logic [31:0]        score_r   [svm4_pkg::NUM_CLASSES];
  logic [31:0]        sum       [svm4_pkg::NUM_CLASSES];
  logic signed [17:0] dot       [svm4_pkg::NUM_CLASSES];
  logic               out_valid_r;
  logic               out_valid_nxt;
  logic               out_free;

  assign out_free = !out_valid_r || !out_stall;
  assign pop      = head_valid && (!head_data.last || out_free);

  for (genvar c = 0; c < svm4_pkg::NUM_CLASSES; c++) begin : g_cls
    logic [31:0] base;

    assign dot[c] = head_data.active ? dot4(head_data.feat, head_data.weight[c]) : '0;
    assign base   = head_data.first ? bias_r[c] : acc_r[c];
    assign sum[c] = base + 32'(dot[c]);
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      for (int c = 0; c < svm4_pkg::NUM_CLASSES; c++) begin
        acc_r[c] <= sum[c];
      end
    end
    if (pop && head_data.last) begin
      for (int c = 0; c < svm4_pkg::NUM_CLASSES; c++) begin
        score_r[c] <= sum[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < svm4_pkg::NUM_CLASSES; c++) begin
        bias_r[c] <= '0;
      end
    end else if (cfg_valid) begin
      unique case (cfg_index)
        svm4_pkg::CFG_BIAS0: bias_r[0] <= cfg_data;
        svm4_pkg::CFG_BIAS1: bias_r[1] <= cfg_data;
        svm4_pkg::CFG_BIAS2: bias_r[2] <= cfg_data;
        svm4_pkg::CFG_BIAS3: bias_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign out_valid_nxt = (pop && head_data.last) ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_score0 = $signed(score_r[0]);
  assign out_score1 = $signed(score_r[1]);
  assign out_score2 = $signed(score_r[2]);
  assign out_score3 = $signed(score_r[3]);

endmodule

`default_nettype wire

// ----- design/int8_linear_svm_four_class_unit.sv -----
// A feature item with last set passes the front-end register, the queue and the score register before its scores show.
// Throughput: one item per cycle while in_stall is low; the weight rows give one word per class per cycle.
// A four-entry queue parts the memory read stage from the accumulate stage.
// Reset (rst_n low, synchronous) clears biases, feature position, queue and out_valid.
// Weight memory contents are undefined until loaded; no clearing pass.
`default_nettype none

module int8_linear_svm_four_class_unit #(
  parameter int unsigned FEATURE_WORDS = svm4_pkg::FEATURE_WORDS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_action,
  input  logic [1:0]         in_class_sel,
  input  logic [7:0]         in_word_addr,
  input  logic signed [7:0]  in_byte0,
  input  logic signed [7:0]  in_byte1,
  input  logic signed [7:0]  in_byte2,
  input  logic signed [7:0]  in_byte3,
  input  logic               in_last,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_score0,
  output logic signed [31:0] out_score1,
  output logic signed [31:0] out_score2,
  output logic signed [31:0] out_score3,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  logic                        q_push;
  svm4_pkg::work_t             q_push_data;
  logic                        q_pop;
  logic                        q_head_valid;
  svm4_pkg::work_t             q_head_data;
  logic [svm4_pkg::QLVL_W-1:0] q_level;

  assign cfg_ready = 1'b1;

  svm4_front #(
    .FeatureWords (FEATURE_WORDS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_action    (in_action),
    .in_class_sel (in_class_sel),
    .in_word_addr (in_word_addr),
    .in_byte0     (in_byte0),
    .in_byte1     (in_byte1),
    .in_byte2     (in_byte2),
    .in_byte3     (in_byte3),
    .in_last      (in_last),
    .q_level      (q_level),
    .push         (q_push),
    .push_data    (q_push_data)
  );

  svm4_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_push_data),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_data  (q_head_data),
    .level      (q_level)
  );

  svm4_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .head_valid (q_head_valid),
    .head_data  (q_head_data),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_score0 (out_score0),
    .out_score1 (out_score1),
    .out_score2 (out_score2),
    .out_score3 (out_score3)
  );

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_level <= svm4_pkg::QLVL_W'(svm4_pkg::QUEUE_DEPTH))
    else $error("queue level beyond depth");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (q_level < svm4_pkg::QLVL_W'(svm4_pkg::QUEUE_DEPTH)))
    else $error("push into full queue");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(q_pop && q_head_data.last))
    else $error("result without a last feature item");

endmodule

`default_nettype wire

// ----- bench/svm4_score_checker.sv -----
// Score checker for the four-class int8 linear SVM unit: watches the item,
// result and register-write channels, predicts each score set and compares.
// Depends on svm4_pkg for the action codes and the class count.
`default_nettype none

module svm4_score_checker
  import svm4_pkg::*;
#(
  parameter int unsigned FEATURE_WORDS = FEATURE_WORDS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic              in_action,
  input  logic [1:0]        in_class_sel,
  input  logic [7:0]        in_word_addr,
  input  logic [7:0]        in_byte0,
  input  logic [7:0]        in_byte1,
  input  logic [7:0]        in_byte2,
  input  logic [7:0]        in_byte3,
  input  logic              in_last,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [31:0]       out_score0,
  input  logic [31:0]       out_score1,
  input  logic [31:0]       out_score2,
  input  logic [31:0]       out_score3,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  output int unsigned       failures,
  output int                pending
);

  typedef logic [NUM_CLASSES-1:0][31:0] score_set_t;

  logic [31:0] weight_rows [NUM_CLASSES][FEATURE_WORDS];
  logic [31:0] bias        [NUM_CLASSES];
  logic [31:0] class_sum   [NUM_CLASSES];
  int unsigned word_pos;
  score_set_t  expected_scores [$];

  function automatic logic [31:0] word_dot(input logic [31:0] feat, input logic [31:0] w);
    int sum;
    int prod;
    logic signed [7:0] f;
    logic signed [7:0] g;
    sum = 0;
    for (int k = 0; k < 4; k++) begin
      f = feat[8*k +: 8];
      g = w[8*k +: 8];
      prod = int'(f) * int'(g);
      sum = sum + prod;
    end
    return sum;
  endfunction

  task automatic check_scores();
    score_set_t want;
    score_set_t got;
    got = {out_score3, out_score2, out_score1, out_score0};
    if (expected_scores.size() == 0) begin
      failures++;
      $error("score set with none expected: %0d %0d %0d %0d", $signed(out_score0),
             $signed(out_score1), $signed(out_score2), $signed(out_score3));
    end else begin
      want = expected_scores.pop_front();
      for (int c = 0; c < NUM_CLASSES; c++) begin
        if (got[c] !== want[c]) begin
          failures++;
          $error("score%0d: expected %0d, got %0d", c, $signed(want[c]), $signed(got[c]));
        end
      end
    end
  endtask

  task automatic take_item();
    logic [31:0] word;
    score_set_t scores;
    word = {in_byte3, in_byte2, in_byte1, in_byte0};
    if (in_action == ACT_LOAD) begin
      if (in_word_addr < FEATURE_WORDS) weight_rows[in_class_sel][in_word_addr] = word;
    end else begin
      if (word_pos == 0) begin
        for (int c = 0; c < NUM_CLASSES; c++) class_sum[c] = bias[c];
      end
      if (word_pos < FEATURE_WORDS) begin
        for (int c = 0; c < NUM_CLASSES; c++)
          class_sum[c] = class_sum[c] + word_dot(word, weight_rows[c][word_pos]);
        word_pos++;
      end
      if (in_last) begin
        for (int c = 0; c < NUM_CLASSES; c++) begin
          scores[c] = class_sum[c];
          class_sum[c] = bias[c];
        end
        expected_scores.push_back(scores);
        word_pos = 0;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        bias[c] = '0;
        class_sum[c] = '0;
      end
      word_pos = 0;
      expected_scores.delete();
      failures = 0;
    end else begin
      if (out_valid && !out_stall) check_scores();
      if (cfg_valid && cfg_ready) bias[cfg_index] = cfg_data;
      if (in_valid && !in_stall) take_item();
    end
    pending = expected_scores.size();
  end

endmodule

`default_nettype wire

// ----- bench/tb_int8_linear_svm_four_class_unit.sv -----
// Testbench top for the four-class int8 linear SVM unit: drives weight loads,
// feature vectors, bias writes and output stalls, and reports the verdict.
// Depends on svm4_pkg, the unit itself and svm4_score_checker.
`default_nettype none

module tb_int8_linear_svm_four_class_unit
  import svm4_pkg::*;
;

  localparam int unsigned FEATURE_WORDS = FEATURE_WORDS_DEF;
  localparam int          HOLD_CYCLES   = 80;
  localparam int          SETTLE_CYCLES = 6;

  logic              clk          = 1'b0;
  logic              rst_n        = 1'b0;
  logic              in_valid     = 1'b0;
  logic              in_stall;
  logic              in_action    = ACT_LOAD;
  logic [1:0]        in_class_sel = '0;
  logic [7:0]        in_word_addr = '0;
  logic [7:0]        in_byte0     = '0;
  logic [7:0]        in_byte1     = '0;
  logic [7:0]        in_byte2     = '0;
  logic [7:0]        in_byte3     = '0;
  logic              in_last      = 1'b0;
  logic              out_valid;
  logic              out_stall    = 1'b0;
  logic [31:0]       out_score0;
  logic [31:0]       out_score1;
  logic [31:0]       out_score2;
  logic [31:0]       out_score3;
  logic              cfg_valid    = 1'b0;
  logic              cfg_ready;
  logic [1:0]        cfg_index    = '0;
  logic [31:0]       cfg_data     = '0;
  int unsigned       failures;
  int                pending;

  bit hold_req = 1'b0;
  bit holding  = 1'b0;

  bit loaded [NUM_CLASSES][FEATURE_WORDS];
  int ready_len = 0;
  int vec_pos   = 0;
  int items_sent = 0;

  int8_linear_svm_four_class_unit u_top (.*);

  svm4_score_checker u_checker (.*);

  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic int stall_len();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int sender_gap();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return 0;
    if (r < 9) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0: return 8'h80;
      1: return 8'h7F;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] rand_word();
    return {rand_byte(), rand_byte(), rand_byte(), rand_byte()};
  endfunction

  function automatic logic [31:0] rand_bias();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic int vec_len();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return $urandom_range(1, 4);
    if (r < 9) return $urandom_range(5, 12);
    return $urandom_range(13, 40);
  endfunction

  // Output side: random stalls, free runs, and one long hold on request.
  initial begin
    bit hold_seen;
    int n;
    hold_seen = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        holding = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        holding = 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat (stall_len()) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        n = $urandom_range(1, 40);
        while (n > 0 && hold_req == hold_seen) begin
          @(posedge clk);
          n--;
        end
      end
    end
  end

  task automatic offer(input logic act, input logic [1:0] cls, input logic [7:0] addr,
                       input logic [31:0] word, input logic lst, input bit no_gap);
    int gap;
    gap = no_gap ? 0 : sender_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_action    <= act;
    in_class_sel <= cls;
    in_word_addr <= addr;
    in_byte0     <= word[7:0];
    in_byte1     <= word[15:8];
    in_byte2     <= word[23:16];
    in_byte3     <= word[31:24];
    in_last      <= lst;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic load_word(input logic [1:0] cls, input logic [7:0] addr,
                           input logic [31:0] word, input logic lst);
    offer(ACT_LOAD, cls, addr, word, lst, 1'b0);
    if (addr < FEATURE_WORDS) loaded[cls][addr] = 1'b1;
    while (ready_len < FEATURE_WORDS && loaded[0][ready_len] && loaded[1][ready_len] &&
           loaded[2][ready_len] && loaded[3][ready_len])
      ready_len++;
  endtask

  // Load any missing weight word at the current position before reading it.
  task automatic feed_word(input logic [31:0] feat, input logic lst, input bit no_gap);
    for (int c = 0; c < NUM_CLASSES; c++) begin
      if (vec_pos < FEATURE_WORDS && !loaded[c][vec_pos])
        load_word(2'(c), 8'(vec_pos), rand_word(), 1'($urandom));
    end
    offer(ACT_FEATURE, 2'($urandom), 8'($urandom), feat, lst, no_gap);
    if (lst) vec_pos = 0;
    else if (vec_pos < FEATURE_WORDS) vec_pos++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_biases(input logic [31:0] b0, input logic [31:0] b1,
                            input logic [31:0] b2, input logic [31:0] b3);
    logic [31:0] vals [NUM_CLASSES];
    vals[0] = b0;
    vals[1] = b1;
    vals[2] = b2;
    vals[3] = b3;
    for (int i = 0; i < NUM_CLASSES; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= cfg_reg_t'(i);
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic retune(input logic [31:0] b0, input logic [31:0] b1,
                        input logic [31:0] b2, input logic [31:0] b3);
    drain();
    set_biases(b0, b1, b2, b3);
  endtask

  task automatic random_segment();
    int kind;
    int n;
    int c;
    kind = $urandom_range(0, 19);
    if (kind < 4) begin
      n = $urandom_range(1, 8);
      repeat (n) begin
        if (ready_len < FEATURE_WORDS && $urandom_range(0, 3) != 0) begin
          c = 0;
          while (loaded[c][ready_len]) c++;
          load_word(2'(c), 8'(ready_len), rand_word(), 1'($urandom));
        end else begin
          load_word(2'($urandom), 8'($urandom), rand_word(), 1'($urandom));
        end
      end
    end else if (kind < 16) begin
      n = vec_len();
      for (int i = 0; i < n; i++) feed_word(rand_word(), i == n - 1, 1'b0);
    end else if (kind < 18) begin
      n = $urandom_range(1, 3);
      repeat (n) feed_word(rand_word(), 1'b0, 1'b0);
    end else begin
      retune(rand_bias(), rand_bias(), rand_bias(), rand_bias());
    end
  endtask

  initial begin
    int base;
    int n;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    set_biases(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0001);
    load_word(2'd0, 8'd0, 32'h7F7F_7F7F, 1'b0);
    load_word(2'd1, 8'd0, 32'h8080_8080, 1'b0);
    load_word(2'd2, 8'd0, 32'h807F_01FF, 1'b1);
    load_word(2'd3, 8'd0, 32'h0000_0000, 1'b0);
    load_word(2'd0, 8'd1, 32'h8080_8080, 1'b1);
    load_word(2'd1, 8'd1, 32'h7F7F_7F7F, 1'b0);
    load_word(2'd2, 8'd1, 32'hFFFF_FFFF, 1'b0);
    load_word(2'd3, 8'd1, 32'h017F_80FF, 1'b1);
    load_word(2'd3, 8'd255, 32'h7F80_FF01, 1'b1);
    feed_word(32'h7F7F_7F7F, 1'b1, 1'b0);
    feed_word(32'h8080_8080, 1'b1, 1'b0);
    feed_word(32'h0000_0000, 1'b0, 1'b0);
    feed_word(32'h01FF_807F, 1'b1, 1'b0);
    // weight overwritten inside an open vector
    feed_word(32'h8080_8080, 1'b0, 1'b0);
    load_word(2'd2, 8'd1, 32'h8080_807F, 1'b0);
    feed_word(32'h7F80_7F80, 1'b1, 1'b0);
    // bias changed while a vector is open
    feed_word(32'hFF01_FF01, 1'b0, 1'b0);
    retune(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'h1234_5678);
    feed_word(32'h807F_807F, 1'b1, 1'b0);
    feed_word(32'h0102_0304, 1'b1, 1'b0);

    base = items_sent;
    while (items_sent - base < 360) random_segment();

    // hold the output so the queue fills and the input stalls
    in_valid <= 1'b0;
    hold_req <= ~hold_req;
    @(posedge clk);
    while (!holding) @(posedge clk);
    repeat (40) feed_word(rand_word(), 1'b1, 1'b1);

    base = items_sent;
    while (items_sent - base < 360) random_segment();
    if (vec_pos != 0) feed_word(rand_word(), 1'b1, 1'b0);

    in_valid <= 1'b0;
    @(posedge clk);
    n = 0;
    while (pending != 0 && n < 20000) begin
      @(posedge clk);
      n++;
    end
    repeat (10) @(posedge clk);
    if (failures == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
design/svm4_pkg.sv
design/svm4_front.sv
design/svm4_queue.sv
design/svm4_back.sv
design/int8_linear_svm_four_class_unit.sv
bench/svm4_score_checker.sv
bench/tb_int8_linear_svm_four_class_unit.sv
